/* hdl/assert_macros.svh */
// Assertion macros shared by the line-of-fire occlusion RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Whenever ante holds, cons must hold on the same edge.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// cond must never be seen high.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");

`endif

/* hdl/lofwo_pkg.sv */
// Shared types and constants for the line-of-fire wall occlusion block.
// No dependencies; imported by lofwo_cell and line_of_fire_wall_occlusion.
package lofwo_pkg;

	localparam int COORD_BITS    = 12;
	localparam int SLOT_BITS     = 4;
	localparam int COUNT_BITS    = 5;
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = COORD_BITS;
	localparam int MAX_WALLS_DEF = 16;

	typedef logic [COORD_BITS-1:0]          coord_t;
	typedef logic signed [COORD_BITS:0]     delta_t;
	typedef logic signed [2*COORD_BITS+1:0] prod_t;
	typedef logic signed [2*COORD_BITS+2:0] cross_t;

	typedef enum logic {
		REQ_LOAD  = 1'b0,
		REQ_QUERY = 1'b1
	} req_kind_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_SHOOTER_X  = 2'd0,
		REG_SHOOTER_Y  = 2'd1,
		REG_WALL_COUNT = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic                 req_type;
		logic [SLOT_BITS-1:0] wall_slot;
		coord_t               corner_a_x;
		coord_t               corner_a_y;
		coord_t               corner_b_x;
		coord_t               corner_b_y;
		coord_t               target_x;
		coord_t               target_y;
	} req_t;

	typedef struct packed {
		logic                 path_clear;
		logic [SLOT_BITS-1:0] blocking_wall;
	} rsp_t;

	// Token moving down the chain. For a load, lo/hi carry the normalized wall;
	// for a query, they carry the bounding box of the segment.
	typedef struct packed {
		logic                 is_query;
		logic [SLOT_BITS-1:0] slot;
		coord_t               lo_x;
		coord_t               hi_x;
		coord_t               lo_y;
		coord_t               hi_y;
		delta_t               dx;
		delta_t               dy;
	} token_t;

	typedef struct packed {
		logic                 found;
		logic [SLOT_BITS-1:0] idx;
	} hit_t;

	typedef struct packed {
		coord_t min_x;
		coord_t max_x;
		coord_t min_y;
		coord_t max_y;
	} wall_t;

endpackage

/* hdl/lofwo_cell.sv */
// One wall cell of the occlusion chain: stores one rectangle and tests passing queries.
// Depends on lofwo_pkg. Two register stages per cell.
module lofwo_cell
	import lofwo_pkg::*;
#(
	parameter int IDX = 0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  coord_t                shooter_x,
	input  coord_t                shooter_y,
	input  logic [COUNT_BITS-1:0] wall_count,
	input  logic                  in_vld,
	input  token_t                in_tok,
	input  hit_t                  in_hit,
	output logic                  out_vld,
	output token_t                out_tok,
	output hit_t                  out_hit
);

	wall_t  wall_q;

	delta_t ex0, ex1, ey0, ey1;
	prod_t  a0, a1, b0, b1;
	logic   in_box, active;

	logic   vld_s1;
	token_t tok_s1;
	hit_t   hit_s1;
	logic   cand_s1;
	prod_t  a0_s1, a1_s1, b0_s1, b1_s1;

	cross_t c00, c10, c01, c11;
	logic   all_pos, all_neg;
	hit_t   hit_nxt;

	logic   vld_s2;
	token_t tok_s2;
	hit_t   hit_s2;

	// Load transaction addressed to this cell
	always_ff @(posedge clk) begin
		if (in_vld && !in_tok.is_query && int'(in_tok.slot) == IDX) begin
			wall_q <= '{min_x: in_tok.lo_x, max_x: in_tok.hi_x,
			            min_y: in_tok.lo_y, max_y: in_tok.hi_y};
		end
	end

	// Stage 1: corner offsets times segment direction, box overlap
	assign ex0 = delta_t'({1'b0, wall_q.min_x}) - delta_t'({1'b0, shooter_x});
	assign ex1 = delta_t'({1'b0, wall_q.max_x}) - delta_t'({1'b0, shooter_x});
	assign ey0 = delta_t'({1'b0, wall_q.min_y}) - delta_t'({1'b0, shooter_y});
	assign ey1 = delta_t'({1'b0, wall_q.max_y}) - delta_t'({1'b0, shooter_y});
	assign a0  = ex0 * in_tok.dy;
	assign a1  = ex1 * in_tok.dy;
	assign b0  = ey0 * in_tok.dx;
	assign b1  = ey1 * in_tok.dx;

	assign in_box = !(in_tok.hi_x < wall_q.min_x || in_tok.lo_x > wall_q.max_x ||
	                  in_tok.hi_y < wall_q.min_y || in_tok.lo_y > wall_q.max_y);
	assign active = int'(wall_count) > IDX;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		tok_s1  <= in_tok;
		hit_s1  <= in_hit;
		cand_s1 <= in_box && active;
		a0_s1   <= a0;
		a1_s1   <= a1;
		b0_s1   <= b0;
		b1_s1   <= b1;
	end

	// Stage 2: sides of the four corners against the line
	assign c00 = cross_t'(a0_s1) - cross_t'(b0_s1);
	assign c10 = cross_t'(a1_s1) - cross_t'(b0_s1);
	assign c01 = cross_t'(a0_s1) - cross_t'(b1_s1);
	assign c11 = cross_t'(a1_s1) - cross_t'(b1_s1);
	assign all_pos = (c00 > 0) && (c10 > 0) && (c01 > 0) && (c11 > 0);
	assign all_neg = (c00 < 0) && (c10 < 0) && (c01 < 0) && (c11 < 0);

	always_comb begin
		hit_nxt = hit_s1;
		if (tok_s1.is_query && !hit_s1.found && cand_s1 && !(all_pos || all_neg)) begin
			hit_nxt.found = 1'b1;
			hit_nxt.idx   = SLOT_BITS'(IDX);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		tok_s2 <= tok_s1;
		hit_s2 <= hit_nxt;
	end

	assign out_vld = vld_s2;
	assign out_tok = tok_s2;
	assign out_hit = hit_s2;

endmodule

/* hdl/line_of_fire_wall_occlusion.sv */
// Top level of the line-of-fire wall occlusion block: config, entry stage, cell chain.
// Depends on lofwo_pkg, lofwo_cell and assert_macros.svh.
//
// Usage:
//   Configuration: cfg_we with cfg_idx selects shooter_x, shooter_y or wall_count;
//   cfg_wdata is taken at the same edge. Write only while no query is in flight.
//   Requests: a transaction is taken at each edge with start high and busy low.
//   busy stays low: the chain accepts one transaction per cycle, loads and
//   queries mixed in any order.
//   A load (req_type 0) writes the normalized rectangle into cell wall_slot and
//   gives no result. A query (req_type 1) tests the segment from the shooter to
//   the target against walls 0 .. wall_count-1 in order.
//   Each query gives one result: done is high for one cycle with result valid.
//   The query passes through the entry register, two register stages per wall
//   cell and the output register.
//   Transactions leave the chain in the order they entered; a query sees every
//   load accepted before it.
//   The receiver cannot stall; results must be taken when done is high.
//   Reset clears the configuration registers and all in-flight transactions.
//   Wall contents are undefined until loaded.
module line_of_fire_wall_occlusion
	import lofwo_pkg::*;
#(
	parameter int MAX_WALLS = MAX_WALLS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  req_t                     req,
	output logic                     done,
	output rsp_t                     result,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_idx,
	input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

	`include "assert_macros.svh"

	localparam int LAT = 2 * MAX_WALLS + 2;

	coord_t                shooter_x_q;
	coord_t                shooter_y_q;
	logic [COUNT_BITS-1:0] wall_count_q;

	logic   accept;
	token_t ent_tok;
	logic   ent_vld_q;
	token_t ent_tok_q;

	logic   chain_vld [MAX_WALLS+1];
	token_t chain_tok [MAX_WALLS+1];
	hit_t   chain_hit [MAX_WALLS+1];

	logic   done_q;
	rsp_t   result_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shooter_x_q  <= '0;
			shooter_y_q  <= '0;
			wall_count_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_idx))
				REG_SHOOTER_X:  shooter_x_q  <= cfg_wdata;
				REG_SHOOTER_Y:  shooter_y_q  <= cfg_wdata;
				REG_WALL_COUNT: wall_count_q <= cfg_wdata[COUNT_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Entry: sort wall corners, or form segment box and direction
	always_comb begin
		ent_tok          = '0;
		ent_tok.is_query = (req.req_type == REQ_QUERY);
		ent_tok.slot     = req.wall_slot;
		if (req.req_type == REQ_QUERY) begin
			ent_tok.lo_x = (shooter_x_q < req.target_x) ? shooter_x_q : req.target_x;
			ent_tok.hi_x = (shooter_x_q < req.target_x) ? req.target_x : shooter_x_q;
			ent_tok.lo_y = (shooter_y_q < req.target_y) ? shooter_y_q : req.target_y;
			ent_tok.hi_y = (shooter_y_q < req.target_y) ? req.target_y : shooter_y_q;
			ent_tok.dx   = delta_t'({1'b0, req.target_x}) - delta_t'({1'b0, shooter_x_q});
			ent_tok.dy   = delta_t'({1'b0, req.target_y}) - delta_t'({1'b0, shooter_y_q});
		end else begin
			ent_tok.lo_x = (req.corner_a_x < req.corner_b_x) ? req.corner_a_x : req.corner_b_x;
			ent_tok.hi_x = (req.corner_a_x < req.corner_b_x) ? req.corner_b_x : req.corner_a_x;
			ent_tok.lo_y = (req.corner_a_y < req.corner_b_y) ? req.corner_a_y : req.corner_b_y;
			ent_tok.hi_y = (req.corner_a_y < req.corner_b_y) ? req.corner_b_y : req.corner_a_y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_vld_q <= 1'b0;
		end else begin
			ent_vld_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		ent_tok_q <= ent_tok;
	end

	assign chain_vld[0] = ent_vld_q;
	assign chain_tok[0] = ent_tok_q;
	assign chain_hit[0] = '0;

	for (genvar i = 0; i < MAX_WALLS; i++) begin : g_cell
		lofwo_cell #(
			.IDX (i)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.shooter_x  (shooter_x_q),
			.shooter_y  (shooter_y_q),
			.wall_count (wall_count_q),
			.in_vld     (chain_vld[i]),
			.in_tok     (chain_tok[i]),
			.in_hit     (chain_hit[i]),
			.out_vld    (chain_vld[i+1]),
			.out_tok    (chain_tok[i+1]),
			.out_hit    (chain_hit[i+1])
		);
	end

	// Output register; loads drop out here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= chain_vld[MAX_WALLS] && chain_tok[MAX_WALLS].is_query;
		end
	end

	always_ff @(posedge clk) begin
		result_q.path_clear    <= !chain_hit[MAX_WALLS].found;
		result_q.blocking_wall <= chain_hit[MAX_WALLS].idx;
	end

	assign done   = done_q;
	assign result = result_q;

	`ASSERT_IMPL(a_done_needs_query, clk, arst_n, done,
		$past(start && !busy && req.req_type == REQ_QUERY, LAT))
	`ASSERT_NEVER(a_clear_has_no_wall, clk, arst_n,
		done && result.path_clear && result.blocking_wall != '0)

endmodule
